>>> sv/fsc_pkg.sv
package fsc_pkg;

  // tachometer counter width and the mask for its captures
  localparam int unsigned CounterWidth = 32;
  localparam logic [31:0] CntMask      = 32'((64'd1 << CounterWidth) - 64'd1);

  // shared divider sizes
  localparam int unsigned DvdW    = 37;
  localparam int unsigned DvsW    = 32;
  localparam int unsigned DivCntW = $clog2(DvdW);

  // microcode address width
  localparam int unsigned StepW = 5;

  // configuration register indexes
  localparam logic [2:0] CfgMaxSpeed  = 3'd0;
  localparam logic [2:0] CfgNomSpeed  = 3'd1;
  localparam logic [2:0] CfgOffset    = 3'd2;
  localparam logic [2:0] CfgMinDuty   = 3'd3;
  localparam logic [2:0] CfgPwmPeriod = 3'd4;
  localparam logic [2:0] CfgMargin    = 3'd5;
  localparam logic [2:0] CfgClockHz   = 3'd6;

  // configuration reset values
  localparam logic [15:0]        RstMaxSpeed  = 16'd3000;
  localparam logic [15:0]        RstNomSpeed  = 16'd1500;
  localparam logic signed [15:0] RstOffset    = 16'sd0;
  localparam logic [6:0]         RstMinDuty   = 7'd20;
  localparam logic [15:0]        RstPwmPeriod = 16'd1000;
  localparam logic [15:0]        RstMargin    = 16'd500;
  localparam logic [31:0]        RstClockHz   = 32'd1000000;

  // item kinds
  localparam logic [1:0] ModeTach = 2'd0;
  localparam logic [1:0] ModeCmd  = 2'd1;
  localparam logic [1:0] ModeTick = 2'd2;

  // commands
  localparam logic [2:0] CmdStart = 3'd0;
  localparam logic [2:0] CmdStop  = 3'd1;
  localparam logic [2:0] CmdMax   = 3'd2;
  localparam logic [2:0] CmdNom   = 3'd3;
  localparam logic [2:0] CmdOff   = 3'd4;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PERIOD,
    OP_DIV_TACH,
    OP_SPEED_WB,
    OP_SPEED_ZERO,
    OP_MON_ON,
    OP_MON_OFF,
    OP_TICK,
    OP_LD_MAX,
    OP_LD_NOM,
    OP_LD_ZERO,
    OP_SUM,
    OP_DIV_DUTY,
    OP_DIV_FLOOR,
    OP_DUTY_WB,
    OP_GOAL_ZERO
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_BUSY,
    COND_PERIOD_ZERO,
    COND_RPM_ZERO,
    COND_BELOW
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
    logic             last;
  } uword_t;

  typedef struct packed {
    logic accept;
    op_e  op;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic period_zero;
    logic rpm_zero;
    logic below;
  } stat_t;

  typedef struct packed {
    logic [15:0] pwm_compare;
    logic [15:0] target_rpm;
    logic [31:0] measured_rpm;
    logic        monitor_on;
    logic        led_valid;
    logic        led_on;
    logic        fan_fault;
  } res_t;

  // program addresses
  localparam logic [StepW-1:0] AddrTach      = StepW'(0);
  localparam logic [StepW-1:0] AddrTachChk   = StepW'(1);
  localparam logic [StepW-1:0] AddrTachDiv   = StepW'(2);
  localparam logic [StepW-1:0] AddrTachWait  = StepW'(3);
  localparam logic [StepW-1:0] AddrTachWb    = StepW'(4);
  localparam logic [StepW-1:0] AddrTachZero  = StepW'(5);
  localparam logic [StepW-1:0] AddrMonOn     = StepW'(6);
  localparam logic [StepW-1:0] AddrMonOff    = StepW'(7);
  localparam logic [StepW-1:0] AddrTick      = StepW'(8);
  localparam logic [StepW-1:0] AddrNop       = StepW'(9);
  localparam logic [StepW-1:0] AddrLdMax     = StepW'(10);
  localparam logic [StepW-1:0] AddrLdNom     = StepW'(11);
  localparam logic [StepW-1:0] AddrLdZero    = StepW'(12);
  localparam logic [StepW-1:0] AddrRpmChk    = StepW'(13);
  localparam logic [StepW-1:0] AddrSum       = StepW'(14);
  localparam logic [StepW-1:0] AddrBelowChk  = StepW'(15);
  localparam logic [StepW-1:0] AddrDutyDiv   = StepW'(16);
  localparam logic [StepW-1:0] AddrDutyWait  = StepW'(17);
  localparam logic [StepW-1:0] AddrDutyWb    = StepW'(18);
  localparam logic [StepW-1:0] AddrFloorDiv  = StepW'(19);
  localparam logic [StepW-1:0] AddrGoalZero  = StepW'(20);

  function automatic uword_t mk_word(input op_e op, input cond_e cond,
                                     input logic [StepW-1:0] target, input logic last);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // control store
  function automatic uword_t urom(input logic [StepW-1:0] addr);
    uword_t w;
    unique case (addr)
      AddrTach:     w = mk_word(OP_PERIOD,     COND_NONE,        AddrTach,     1'b0);
      AddrTachChk:  w = mk_word(OP_NONE,       COND_PERIOD_ZERO, AddrTachZero, 1'b0);
      AddrTachDiv:  w = mk_word(OP_DIV_TACH,   COND_NONE,        AddrTach,     1'b0);
      AddrTachWait: w = mk_word(OP_NONE,       COND_BUSY,        AddrTachWait, 1'b0);
      AddrTachWb:   w = mk_word(OP_SPEED_WB,   COND_NONE,        AddrTach,     1'b1);
      AddrTachZero: w = mk_word(OP_SPEED_ZERO, COND_NONE,        AddrTach,     1'b1);
      AddrMonOn:    w = mk_word(OP_MON_ON,     COND_NONE,        AddrTach,     1'b1);
      AddrMonOff:   w = mk_word(OP_MON_OFF,    COND_NONE,        AddrTach,     1'b1);
      AddrTick:     w = mk_word(OP_TICK,       COND_NONE,        AddrTach,     1'b1);
      AddrNop:      w = mk_word(OP_NONE,       COND_NONE,        AddrTach,     1'b1);
      AddrLdMax:    w = mk_word(OP_LD_MAX,     COND_ALWAYS,      AddrRpmChk,   1'b0);
      AddrLdNom:    w = mk_word(OP_LD_NOM,     COND_ALWAYS,      AddrRpmChk,   1'b0);
      AddrLdZero:   w = mk_word(OP_LD_ZERO,    COND_NONE,        AddrTach,     1'b0);
      AddrRpmChk:   w = mk_word(OP_NONE,       COND_RPM_ZERO,    AddrGoalZero, 1'b0);
      AddrSum:      w = mk_word(OP_SUM,        COND_NONE,        AddrTach,     1'b0);
      AddrBelowChk: w = mk_word(OP_NONE,       COND_BELOW,       AddrFloorDiv, 1'b0);
      AddrDutyDiv:  w = mk_word(OP_DIV_DUTY,   COND_NONE,        AddrTach,     1'b0);
      AddrDutyWait: w = mk_word(OP_NONE,       COND_BUSY,        AddrDutyWait, 1'b0);
      AddrDutyWb:   w = mk_word(OP_DUTY_WB,    COND_NONE,        AddrTach,     1'b1);
      AddrFloorDiv: w = mk_word(OP_DIV_FLOOR,  COND_ALWAYS,      AddrDutyWait, 1'b0);
      AddrGoalZero: w = mk_word(OP_GOAL_ZERO,  COND_NONE,        AddrTach,     1'b1);
      default:      w = mk_word(OP_NONE,       COND_NONE,        AddrTach,     1'b1);
    endcase
    return w;
  endfunction

  // program entry for an accepted word
  function automatic logic [StepW-1:0] entry_addr(input logic [1:0] mode,
                                                  input logic [2:0] cmd);
    logic [StepW-1:0] a;
    unique case (mode)
      ModeTach: a = AddrTach;
      ModeCmd: begin
        unique case (cmd)
          CmdStart: a = AddrMonOn;
          CmdStop:  a = AddrMonOff;
          CmdMax:   a = AddrLdMax;
          CmdNom:   a = AddrLdNom;
          CmdOff:   a = AddrLdZero;
          default:  a = AddrNop;
        endcase
      end
      ModeTick: a = AddrTick;
      default:  a = AddrNop;
    endcase
    return a;
  endfunction

endpackage

>>> sv/fsc_div.sv
module fsc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fsc_pkg::DvdW-1:0]  dividend_i,
  input  logic [fsc_pkg::DvsW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [fsc_pkg::DvdW-1:0]  quotient_o
);
  import fsc_pkg::*;

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0]    dvd_q, dvd_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvsW:0]      rem_shift;
  logic [DvsW:0]      diff;
  logic               fits;

  // one restoring step per cycle, quotient bits shift into the dividend
  always_comb begin
    rem_shift = {rem_q, dvd_q[DvdW-1]};
    diff      = rem_shift - {1'b0, dvs_q};
    fits      = rem_shift >= {1'b0, dvs_q};
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    dvd_d     = dvd_q;
    dvs_d     = dvs_q;
    rem_d     = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DvdW - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[DvsW-1:0] : rem_shift[DvsW-1:0];
      dvd_d = {dvd_q[DvdW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q;

endmodule

>>> sv/fsc_dpath.sv
module fsc_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [31:0]     capture_value_i,
  input  logic            cfg_valid_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  input  fsc_pkg::ctrl_t  ctrl_i,
  output fsc_pkg::stat_t  stat_o,
  output fsc_pkg::res_t   res_o
);
  import fsc_pkg::*;

  // configuration
  logic [15:0]        max_q;
  logic [15:0]        nom_q;
  logic signed [15:0] offset_q;
  logic [6:0]         min_duty_q;
  logic [15:0]        period_cfg_q;
  logic [15:0]        margin_q;
  logic [31:0]        clk_hz_q;

  // block state
  logic [31:0] cap_in_q;
  logic [31:0] last_cap_q;
  logic [31:0] last_period_q;
  logic [31:0] speed_q;
  logic [15:0] goal_q;
  logic [15:0] duty_q;
  logic        mon_q;
  logic        fault_q;
  logic        led_valid_q;
  logic        led_on_q;

  // working registers
  logic [15:0]        rpm_q;
  logic signed [17:0] s_q;
  logic [22:0]        mp_q;

  logic [15:0]        ld_src;
  logic [15:0]        ld_clamped;
  logic signed [17:0] s_sum;
  logic signed [25:0] lhs;
  logic signed [25:0] rhs;
  logic [36:0]        tach_prod;
  logic [32:0]        duty_prod;
  logic [22:0]        floor_prod;
  logic [22:0]        mp_prod;
  logic               div_start;
  logic [DvdW-1:0]    div_dvd;
  logic [DvsW-1:0]    div_dvs;
  logic               div_busy;
  logic [DvdW-1:0]    div_quo;
  logic               shortfall;

  // arithmetic feeding the steps
  always_comb begin
    unique case (ctrl_i.op)
      OP_LD_MAX: ld_src = max_q;
      OP_LD_NOM: ld_src = nom_q;
      default:   ld_src = '0;
    endcase
    ld_clamped = (ld_src > max_q) ? max_q : ld_src;
    s_sum      = signed'({2'b00, rpm_q}) + 18'(offset_q);
    lhs        = 26'(s_q) * 26'sd100;
    rhs        = signed'(26'(mp_q));
    tach_prod  = clk_hz_q * 37'd30;
    duty_prod  = s_q[16:0] * period_cfg_q;
    floor_prod = min_duty_q * period_cfg_q;
    mp_prod    = min_duty_q * max_q;
    shortfall  = (goal_q > margin_q) && (speed_q < 32'(goal_q - margin_q));
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_dvd   = 37'(floor_prod);
    div_dvs   = 32'd100;
    unique case (ctrl_i.op)
      OP_DIV_TACH: begin
        div_start = 1'b1;
        div_dvd   = tach_prod;
        div_dvs   = last_period_q;
      end
      OP_DIV_DUTY: begin
        div_start = 1'b1;
        div_dvd   = 37'(duty_prod);
        div_dvs   = 32'(max_q);
      end
      OP_DIV_FLOOR: begin
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  fsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q        <= RstMaxSpeed;
      nom_q        <= RstNomSpeed;
      offset_q     <= RstOffset;
      min_duty_q   <= RstMinDuty;
      period_cfg_q <= RstPwmPeriod;
      margin_q     <= RstMargin;
      clk_hz_q     <= RstClockHz;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMaxSpeed:  max_q        <= cfg_data_i[15:0];
        CfgNomSpeed:  nom_q        <= cfg_data_i[15:0];
        CfgOffset:    offset_q     <= signed'(cfg_data_i[15:0]);
        CfgMinDuty:   min_duty_q   <= cfg_data_i[6:0];
        CfgPwmPeriod: period_cfg_q <= cfg_data_i[15:0];
        CfgMargin:    margin_q     <= cfg_data_i[15:0];
        CfgClockHz:   clk_hz_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state updates driven by the current control word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cap_q    <= '0;
      last_period_q <= '0;
      speed_q       <= '0;
      goal_q        <= '0;
      duty_q        <= '0;
      mon_q         <= 1'b0;
      fault_q       <= 1'b0;
      led_valid_q   <= 1'b0;
      led_on_q      <= 1'b0;
    end else begin
      if (ctrl_i.accept) begin
        led_valid_q <= 1'b0;
        led_on_q    <= 1'b0;
      end
      unique case (ctrl_i.op)
        OP_PERIOD: begin
          if (cap_in_q > last_cap_q) begin
            last_period_q <= cap_in_q - last_cap_q;
          end
          last_cap_q <= cap_in_q;
        end
        OP_SPEED_WB:   speed_q <= (|div_quo[DvdW-1:32]) ? 32'hffff_ffff : div_quo[31:0];
        OP_SPEED_ZERO: speed_q <= '0;
        OP_MON_ON:     mon_q   <= 1'b1;
        OP_MON_OFF:    mon_q   <= 1'b0;
        OP_TICK: begin
          led_valid_q <= mon_q;
          led_on_q    <= mon_q && shortfall;
          if (mon_q && shortfall) begin
            fault_q <= 1'b1;
          end
        end
        OP_DUTY_WB: begin
          goal_q <= rpm_q;
          duty_q <= (|div_quo[DvdW-1:16]) ? 16'hffff : div_quo[15:0];
        end
        OP_GOAL_ZERO: begin
          goal_q <= '0;
          duty_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cap_in_q <= capture_value_i & CntMask;
    end
    unique case (ctrl_i.op)
      OP_LD_MAX, OP_LD_NOM: rpm_q <= ld_clamped;
      OP_LD_ZERO:           rpm_q <= '0;
      OP_SUM: begin
        s_q  <= s_sum;
        mp_q <= mp_prod;
      end
      default: ;
    endcase
  end

  assign stat_o.div_busy    = div_busy;
  assign stat_o.period_zero = (last_period_q == '0);
  assign stat_o.rpm_zero    = (rpm_q == '0);
  assign stat_o.below       = (lhs < rhs);

  assign res_o.pwm_compare  = duty_q;
  assign res_o.target_rpm   = goal_q;
  assign res_o.measured_rpm = speed_q;
  assign res_o.monitor_on   = mon_q;
  assign res_o.led_valid    = led_valid_q;
  assign res_o.led_on       = led_on_q;
  assign res_o.fan_fault    = fault_q;

endmodule

>>> sv/fsc_seq.sv
module fsc_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      mode_i,
  input  logic [2:0]      command_i,
  input  fsc_pkg::stat_t  stat_i,
  input  logic            out_free_i,
  output fsc_pkg::ctrl_t  ctrl_o,
  output logic            load_out_o
);
  import fsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } seq_state_e;

  seq_state_e       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  uword_t           word;
  logic             taken;
  logic             accept;

  assign word   = urom(step_q);
  assign accept = (state_q == ST_IDLE) && in_valid_i;

  // jump condition select
  always_comb begin
    unique case (word.cond)
      COND_NONE:        taken = 1'b0;
      COND_ALWAYS:      taken = 1'b1;
      COND_BUSY:        taken = stat_i.div_busy;
      COND_PERIOD_ZERO: taken = stat_i.period_zero;
      COND_RPM_ZERO:    taken = stat_i.rpm_zero;
      COND_BELOW:       taken = stat_i.below;
      default:          taken = 1'b0;
    endcase
  end

  // step counter and phase control
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    load_out_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          step_d  = entry_addr(mode_i, command_i);
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (word.last) begin
          state_d = ST_DONE;
        end else if (taken) begin
          step_d = word.target;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          load_out_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign ctrl_o.accept = accept;
  assign ctrl_o.op     = (state_q == ST_RUN) ? word.op : OP_NONE;

endmodule

>>> sv/fan_speed_controller.sv
// Fan speed controller with tachometer monitor. Each accepted word (tach
// capture, command or monitor tick) returns one status word carrying the PWM
// compare value, clamped target, measured rpm, monitor and LED flags and the
// sticky fault. A microcoded sequencer steps a small datapath; rpm and duty
// both go through one shared restoring divider that retires one quotient bit
// per cycle for each of the 37 dividend bits. A tach capture with a nonzero
// period and a max or nominal target command whose target does not clamp to
// zero wait on the divider; a zero period capture, start, stop, off, tick and
// ignored words do not.
// One word is in flight at a time; the result register lets the next word in
// while the previous result waits. Configuration writes are taken at once.
module fan_speed_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] capture_value_i,
  input  logic [2:0]  command_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] pwm_compare_o,
  output logic [15:0] target_rpm_o,
  output logic [31:0] measured_rpm_o,
  output logic        monitor_on_o,
  output logic        led_valid_o,
  output logic        led_on_o,
  output logic        fan_fault_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import fsc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q;
  logic  out_free;
  logic  load_out;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  fsc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .command_i  (command_i),
    .stat_i     (stat),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .load_out_o (load_out)
  );

  fsc_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .capture_value_i (capture_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .res_o           (res)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pwm_compare_o  = out_q.pwm_compare;
  assign target_rpm_o   = out_q.target_rpm;
  assign measured_rpm_o = out_q.measured_rpm;
  assign monitor_on_o   = out_q.monitor_on;
  assign led_valid_o    = out_q.led_valid;
  assign led_on_o       = out_q.led_on;
  assign fan_fault_o    = out_q.fan_fault;

`ifndef SYNTHESIS
  // led lit only inside a valid led update
  a_led_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    led_on_o |-> led_valid_o)
    else $error("led_on without led_valid");

  // fault flag never clears once reported
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fan_fault_o) |-> fan_fault_o)
    else $error("fan fault cleared");

  // zero target always comes with zero compare
  a_zero_goal_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (target_rpm_o == 16'd0) |-> (pwm_compare_o == 16'd0))
    else $error("nonzero compare with zero target");

  // no new word while a result is being built
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while busy");
`endif

endmodule

>>> test/tb_fan_speed_controller.sv
`timescale 1ns / 1ps

module tb_fan_speed_controller;
  import fsc_pkg::*;

  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned TailCycles    = 60;
  localparam int unsigned WordsPerBlock = 89;
  localparam int unsigned MaxReports    = 10;

  // codes that the package leaves unnamed
  localparam logic [1:0] ModeIdle     = 2'd3;
  localparam logic [2:0] CmdUnusedLo  = 3'd5;
  localparam logic [2:0] CmdUnusedHi  = 3'd7;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i          = '0;
  logic [31:0] capture_value_i = '0;
  logic [2:0]  command_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [15:0] pwm_compare_o;
  logic [15:0] target_rpm_o;
  logic [31:0] measured_rpm_o;
  logic        monitor_on_o;
  logic        led_valid_o;
  logic        led_on_o;
  logic        fan_fault_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i     = '0;
  logic [31:0] cfg_data_i      = '0;

  fan_speed_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .capture_value_i (capture_value_i),
    .command_i       (command_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pwm_compare_o   (pwm_compare_o),
    .target_rpm_o    (target_rpm_o),
    .measured_rpm_o  (measured_rpm_o),
    .monitor_on_o    (monitor_on_o),
    .led_valid_o     (led_valid_o),
    .led_on_o        (led_on_o),
    .fan_fault_o     (fan_fault_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // controller shadow: configuration
  logic [15:0]        max_rpm;
  logic [15:0]        nom_rpm;
  logic signed [15:0] offset_rpm;
  logic [6:0]         min_duty;
  logic [15:0]        pwm_period;
  logic [15:0]        margin_rpm;
  logic [31:0]        clock_hz;

  // controller shadow: state
  logic [31:0] last_cap;
  logic [31:0] last_period;
  logic [31:0] speed_rpm;
  logic [15:0] goal_rpm;
  logic [15:0] duty_cmp;
  logic        mon_on;
  logic        fault_seen;

  // status words owed by the controller, oldest first
  res_t status_q[$];

  int unsigned send_idle_pct  = 10;
  int unsigned recv_stall_pct = 56;
  int unsigned mismatches     = 0;
  int unsigned n_checked      = 0;
  int unsigned n_tach         = 0;
  int unsigned n_cmd          = 0;
  int unsigned n_tick         = 0;
  int unsigned n_writes       = 0;
  int unsigned cycles         = 0;

  typedef struct {
    bit          is_reg;
    logic [2:0]  idx;
    logic [31:0] data;
    logic [1:0]  mode;
    logic [31:0] cap;
    logic [2:0]  cmd;
    bit          known;
    res_t        want;
  } plan_row_t;

  plan_row_t plan_q[$];

  function automatic void reset_shadow();
    max_rpm     = RstMaxSpeed;
    nom_rpm     = RstNomSpeed;
    offset_rpm  = RstOffset;
    min_duty    = RstMinDuty;
    pwm_period  = RstPwmPeriod;
    margin_rpm  = RstMargin;
    clock_hz    = RstClockHz;
    last_cap    = '0;
    last_period = '0;
    speed_rpm   = '0;
    goal_rpm    = '0;
    duty_cmp    = '0;
    mon_on      = 1'b0;
    fault_seen  = 1'b0;
  endfunction

  function automatic void note_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      CfgMaxSpeed:  max_rpm    = data[15:0];
      CfgNomSpeed:  nom_rpm    = data[15:0];
      CfgOffset:    offset_rpm = data[15:0];
      CfgMinDuty:   min_duty   = data[6:0];
      CfgPwmPeriod: pwm_period = data[15:0];
      CfgMargin:    margin_rpm = data[15:0];
      CfgClockHz:   clock_hz   = data;
      default: ;
    endcase
  endfunction

  // clamp the target and derive the pwm compare with the duty floor
  function automatic void apply_goal(logic [15:0] rpm);
    longint r, o, md, per, mx, s, q;
    if (rpm > max_rpm) rpm = max_rpm;
    if (rpm == 0) begin
      goal_rpm = '0;
      duty_cmp = '0;
      return;
    end
    r   = rpm;
    o   = offset_rpm;
    md  = min_duty;
    per = pwm_period;
    mx  = max_rpm;
    s   = r + o;
    if (s * 100 < md * mx) q = (md * per) / 100;
    else q = (s * per) / mx;
    if (q < 0) q = 0;
    if (q > 65535) q = 65535;
    goal_rpm = rpm;
    duty_cmp = q[15:0];
  endfunction

  function automatic res_t predict_status(logic [1:0] mode, logic [31:0] cap,
                                          logic [2:0] cmd);
    res_t        st;
    logic [31:0] period;
    logic [63:0] quot;
    st = '0;
    case (mode)
      ModeTach: begin
        cap    = cap & CntMask;
        period = (cap > last_cap) ? cap - last_cap : last_period;
        last_period = period;
        last_cap    = cap;
        if (period == 0) begin
          speed_rpm = '0;
        end else begin
          quot = ({32'd0, clock_hz} * 64'd30) / {32'd0, period};
          speed_rpm = (quot > 64'h0000_0000_FFFF_FFFF) ? '1 : quot[31:0];
        end
      end
      ModeCmd: begin
        case (cmd)
          CmdStart: mon_on = 1'b1;
          CmdStop:  mon_on = 1'b0;
          CmdMax:   apply_goal(max_rpm);
          CmdNom:   apply_goal(nom_rpm);
          CmdOff:   apply_goal('0);
          default: ;
        endcase
      end
      ModeTick: begin
        if (mon_on) begin
          st.led_valid = 1'b1;
          if (goal_rpm > margin_rpm && speed_rpm < goal_rpm - margin_rpm) begin
            st.led_on  = 1'b1;
            fault_seen = 1'b1;
          end
        end
      end
      default: ;
    endcase
    st.pwm_compare  = duty_cmp;
    st.target_rpm   = goal_rpm;
    st.measured_rpm = speed_rpm;
    st.monitor_on   = mon_on;
    st.fan_fault    = fault_seen;
    return st;
  endfunction

  function automatic res_t known_status(logic [15:0] pwm, logic [15:0] tgt,
                                        logic [31:0] rpm, logic mon, logic lv,
                                        logic lo, logic flt);
    res_t st;
    st.pwm_compare  = pwm;
    st.target_rpm   = tgt;
    st.measured_rpm = rpm;
    st.monitor_on   = mon;
    st.led_valid    = lv;
    st.led_on       = lo;
    st.fan_fault    = flt;
    return st;
  endfunction

  function automatic void add_word(logic [1:0] mode, logic [31:0] cap, logic [2:0] cmd);
    plan_row_t row;
    row = '{is_reg: 1'b0, idx: '0, data: '0, mode: mode, cap: cap, cmd: cmd,
            known: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  function automatic void add_known(logic [1:0] mode, logic [31:0] cap, logic [2:0] cmd,
                                    res_t want);
    plan_row_t row;
    row = '{is_reg: 1'b0, idx: '0, data: '0, mode: mode, cap: cap, cmd: cmd,
            known: 1'b1, want: want};
    plan_q.push_back(row);
  endfunction

  function automatic void add_reg(logic [2:0] idx, logic [31:0] data);
    plan_row_t row;
    row = '{is_reg: 1'b1, idx: idx, data: data, mode: '0, cap: '0, cmd: '0,
            known: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  function automatic logic [31:0] pick_reg_value(logic [2:0] idx);
    logic [31:0] v;
    v = '0;
    case (idx)
      CfgMaxSpeed: begin
        case ($urandom_range(0, 5))
          0:       v = 32'd1;
          1:       v = 32'd65535;
          2:       v = 32'd0;
          3:       v = {16'd0, RstMaxSpeed};
          default: v = $urandom_range(1, 65535);
        endcase
      end
      CfgNomSpeed: begin
        case ($urandom_range(0, 4))
          0:       v = 32'd0;
          1:       v = 32'd65535;
          2:       v = {16'd0, RstNomSpeed};
          default: v = $urandom_range(0, 65535);
        endcase
      end
      CfgOffset: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h0000_8000;
          1:       v = 32'h0000_7FFF;
          2:       v = 32'd0;
          3, 4:    v = {16'd0, 16'($urandom_range(0, 4000) - 2000)};
          default: v = $urandom_range(0, 65535);
        endcase
      end
      CfgMinDuty: begin
        case ($urandom_range(0, 4))
          0:       v = 32'd0;
          1:       v = 32'd100;
          2:       v = 32'd127;
          default: v = $urandom_range(0, 100);
        endcase
      end
      CfgPwmPeriod: begin
        case ($urandom_range(0, 7))
          0:       v = 32'd1;
          1:       v = 32'd65535;
          2:       v = 32'd0;
          default: v = $urandom_range(1, 65535);
        endcase
      end
      CfgMargin: begin
        case ($urandom_range(0, 4))
          0:       v = 32'd0;
          1:       v = 32'd65535;
          default: v = $urandom_range(0, 3000);
        endcase
      end
      CfgClockHz: begin
        case ($urandom_range(0, 7))
          0:       v = 32'd1;
          1:       v = 32'hFFFF_FFFF;
          2:       v = RstClockHz;
          3:       v = 32'd0;
          4, 5:    v = $urandom_range(100000, 20000000);
          default: v = $urandom;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // hold off the sender until every owed status word has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (status_q.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    note_reg(idx, data);
    n_writes++;
  endtask

  // offer one word; valid stays high after the accept until the next call decides
  task automatic send_word(logic [1:0] mode, logic [31:0] cap, logic [2:0] cmd,
                           bit known, res_t want);
    int unsigned gap;
    res_t        st;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= mode;
    capture_value_i <= cap;
    command_i       <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    st = predict_status(mode, cap, cmd);
    status_q.push_back(known ? want : st);
    case (mode)
      ModeTach: n_tach++;
      ModeCmd:  n_cmd++;
      ModeTick: n_tick++;
      default: ;
    endcase
  endtask

  // status word checker and receiver stalls
  res_t got, owed;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = known_status(pwm_compare_o, target_rpm_o, measured_rpm_o, monitor_on_o,
                         led_valid_o, led_on_o, fan_fault_o);
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected status word: pwm %0d tgt %0d rpm %0d", got.pwm_compare,
                   got.target_rpm, got.measured_rpm);
      end else begin
        owed = status_q.pop_front();
        n_checked++;
        if (got.pwm_compare !== owed.pwm_compare || got.target_rpm !== owed.target_rpm ||
            got.measured_rpm !== owed.measured_rpm || got.monitor_on !== owed.monitor_on ||
            got.led_valid !== owed.led_valid || got.led_on !== owed.led_on ||
            got.fan_fault !== owed.fan_fault) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("status mismatch at word %0d", n_checked);
            $display("  got  pwm %0d tgt %0d rpm %0d mon %b led %b/%b fault %b",
                     got.pwm_compare, got.target_rpm, got.measured_rpm, got.monitor_on,
                     got.led_valid, got.led_on, got.fan_fault);
            $display("  want pwm %0d tgt %0d rpm %0d mon %b led %b/%b fault %b",
                     owed.pwm_compare, owed.target_rpm, owed.measured_rpm, owed.monitor_on,
                     owed.led_valid, owed.led_on, owed.fan_fault);
          end
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d status words owed", cycles, status_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned phase, blk, counted;
    logic [1:0]  mode;
    logic [31:0] cap;
    logic [2:0]  cmd;
    logic [2:0]  idx;

    reset_shadow();

    // directed words at reset settings: idle flags, ignored words, period rules
    add_known(ModeTick, '0, '0, known_status('0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_known(ModeIdle, 32'hFFFF_FFFF, CmdUnusedHi,
              known_status('0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_known(ModeCmd, '0, CmdUnusedLo, known_status('0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_known(ModeCmd, '0, CmdUnusedHi, known_status('0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_known(ModeTach, '0, '0, known_status('0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_known(ModeTach, 32'd1000, '0,
              known_status('0, '0, 32'd30000, 1'b0, 1'b0, 1'b0, 1'b0));
    add_known(ModeTach, 32'd1000, '0,
              known_status('0, '0, 32'd30000, 1'b0, 1'b0, 1'b0, 1'b0));
    add_known(ModeTach, 32'd400, '0,
              known_status('0, '0, 32'd30000, 1'b0, 1'b0, 1'b0, 1'b0));
    add_known(ModeCmd, '0, CmdMax,
              known_status(16'd1000, 16'd3000, 32'd30000, 1'b0, 1'b0, 1'b0, 1'b0));
    add_known(ModeCmd, '0, CmdNom,
              known_status(16'd500, 16'd1500, 32'd30000, 1'b0, 1'b0, 1'b0, 1'b0));
    add_word(ModeCmd, '0, CmdStart);
    add_word(ModeTick, '0, '0);
    add_word(ModeTach, 32'hFFFF_FFFF, '0);
    add_word(ModeTick, '0, '0);
    add_word(ModeCmd, '0, CmdOff);
    add_word(ModeTick, '0, '0);
    add_word(ModeCmd, '0, CmdStop);
    add_word(ModeTick, '0, '0);
    // speed overflow and compare saturation from a large offset
    add_reg(CfgClockHz, 32'hFFFF_FFFF);
    add_reg(CfgMinDuty, 32'd127);
    add_reg(CfgOffset, 32'h0000_7FFF);
    add_reg(CfgMaxSpeed, 32'd65535);
    add_reg(CfgPwmPeriod, 32'd65535);
    add_word(ModeTach, '0, '0);
    add_word(ModeTach, 32'd1, '0);
    add_word(ModeCmd, '0, CmdMax);
    // negative offset lands on the duty floor, over and under full scale
    add_reg(CfgOffset, 32'h0000_8000);
    add_word(ModeCmd, '0, CmdMax);
    add_reg(CfgMinDuty, 32'd100);
    add_reg(CfgPwmPeriod, 32'd1000);
    add_word(ModeCmd, '0, CmdMax);
    // zero max speed clamps every target
    add_reg(CfgMaxSpeed, 32'd0);
    add_word(ModeCmd, '0, CmdNom);
    add_reg(CfgNomSpeed, 32'd65535);
    add_reg(CfgMargin, 32'd0);
    add_reg(CfgMaxSpeed, 32'd3000);
    add_reg(CfgOffset, 32'd0);
    add_word(ModeCmd, '0, CmdNom);
    add_word(ModeCmd, '0, CmdStart);
    add_word(ModeTick, '0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_reg) write_reg(plan_q[i].idx, plan_q[i].data);
      else send_word(plan_q[i].mode, plan_q[i].cap, plan_q[i].cmd, plan_q[i].known,
                     plan_q[i].want);
    end

    // random words under three idle patterns, settings changed per block
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 10; recv_stall_pct = 56; end
        1:       begin send_idle_pct = 56; recv_stall_pct = 10; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (blk = 0; blk < 4; blk++) begin
        for (int r = 0; r < 7; r++) begin
          idx = 3'(r);
          write_reg(idx, pick_reg_value(idx));
        end
        counted = 0;
        while (counted < WordsPerBlock) begin
          cap = $urandom;
          cmd = 3'($urandom_range(0, 7));
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: begin
              mode = ModeTach;
              case ($urandom_range(0, 9))
                0:       cap = $urandom;
                1:       cap = last_cap;
                2:       cap = last_cap - $urandom_range(0, 5000);
                3, 4, 5: cap = last_cap + $urandom_range(1, 300);
                6, 7, 8: cap = last_cap + $urandom_range(300, 200000);
                default: cap = last_cap + $urandom;
              endcase
            end
            8, 9, 10, 11, 12, 13: begin
              mode = ModeCmd;
              if ($urandom_range(0, 9) != 0) cmd = 3'($urandom_range(0, 4));
            end
            14, 15, 16, 17, 18: mode = ModeTick;
            default: mode = ModeIdle;
          endcase
          counted++;
          // now and then let the pipeline run dry before the next word
          if ($urandom_range(0, 49) == 0) drain_results();
          send_word(mode, cap, cmd, 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("ran %0d tach captures, %0d commands, %0d monitor ticks, %0d register writes",
             n_tach, n_cmd, n_tick, n_writes);
    $display("checked %0d status words, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
